// ===== design/fmlis_pkg.sv =====
// ----------------------------------------------------------------------------
// fmlis_pkg
// Shared widths, constants and sequencer states for the Fenwick-tree
// longest-increasing-subsequence core.
// ----------------------------------------------------------------------------
package fmlis_pkg;

    localparam int RANK_W           = 11;
    localparam int LEN_W            = 11;
    localparam int DEF_MAX_RANK     = 1024;
    localparam int IN_TDATA_W       = 16;
    localparam int OUT_TDATA_W      = 24;

    localparam logic [LEN_W-1:0]  LEN_MAX          = 11'd2047;
    localparam logic [RANK_W-1:0] RANK_COUNT_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_SEQ_CLR,
        ST_QUERY,
        ST_LEN,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

// ===== design/fenwick_max_lis_length_core.sv =====
// ----------------------------------------------------------------------------
// fenwick_max_lis_length_core
// Streams compressed ranks through a Fenwick tree of prefix maxima and reports,
// per word, the longest strictly increasing subsequence ending there and the best so far.
// ----------------------------------------------------------------------------
// One input word is handled at a time, using a single tree memory with one
// read and one write port, one shared index adder and one shared comparator.
// After the word is taken the query walks down the tree one entry per cycle,
// the ST_LEN state forms the length, and the update walks up the tree one
// entry per cycle with the write of each entry overlapped with the read of
// the next. With 1024 ranks the query and the update together visit eleven
// entries for any rank in range. A word with sequence_start set first sweeps
// the whole tree to zero, and after reset the same sweep runs before the
// first word is accepted. A finished result sits in an output register, so
// the next word is taken while it waits. The user must write the rank_count
// register through its own channel only while idle; the block itself does
// not enforce this.
module fenwick_max_lis_length_core
    import fmlis_pkg::*;
#(
    parameter int MAX_RANK = DEF_MAX_RANK
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [10:0] rank, [15:11] zero
    input  logic [0:0]             s_axis_tuser,   // [0] sequence_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [10:0] ending_length,
                                                   // [21:11] best_length, [23:22] zero
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RANK_W-1:0]      i_cfg_data      // rank_count
);

    localparam int IW = $clog2(MAX_RANK + 1);
    localparam int XW = IW + 1;
    localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CW = (XW > RANK_W) ? XW : RANK_W;
    localparam logic [CW-1:0] MAXR_C   = CW'(MAX_RANK);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_RANK - 1);

    t_state r_state, n_state;

    logic [RANK_W-1:0] r_rank_count;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic              r_upd_ok, n_upd_ok;
    logic [XW-1:0]     r_idx, n_idx;
    logic [XW-1:0]     r_wr_idx, n_wr_idx;
    logic              r_pend, n_pend;
    logic [LEN_W-1:0]  r_best, n_best;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_run, n_run;
    logic [AW-1:0]     r_clr, n_clr;

    logic              r_out_valid;
    logic [LEN_W-1:0]  r_out_end;
    logic [LEN_W-1:0]  r_out_best;

    logic [LEN_W-1:0]  r_tree [MAX_RANK];
    logic [LEN_W-1:0]  r_rd_data;

    logic              in_accept;
    logic              out_load;
    logic [RANK_W-1:0] in_rank;
    logic [CW-1:0]     rank_c;
    logic [CW-1:0]     size_c;
    logic [CW-1:0]     q_c;
    logic              in_range;
    logic              clr_last;
    logic [XW-1:0]     low_bit;
    logic [XW-1:0]     step_idx;
    logic [XW-1:0]     idx_m1;
    logic [XW-1:0]     wr_idx_m1;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  cmp_a, cmp_b;
    logic              cmp_gt;
    logic              mem_re, mem_we;
    logic [AW-1:0]     mem_ra, mem_wa;
    logic [LEN_W-1:0]  mem_wd;

    assign in_rank   = s_axis_tdata[RANK_W-1:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // Active size is the register clipped to the tree depth.
    assign size_c   = (CW'(r_rank_count) > MAXR_C) ? MAXR_C : CW'(r_rank_count);
    assign rank_c   = CW'(in_rank);
    assign in_range = CW'(r_idx) <= size_c;
    assign clr_last = r_clr == CLR_LAST;

    always_comb begin
        q_c = (rank_c == '0) ? '0 : rank_c - 1'b1;
        if (q_c > size_c) begin
            q_c = size_c;
        end
    end

    // Shared index unit: strip the low set bit going down, add it going up.
    assign low_bit  = r_idx & (~r_idx + 1'b1);
    assign step_idx = (r_state == ST_UPDATE) ? r_idx + low_bit : r_idx - low_bit;
    assign idx_m1    = r_idx - 1'b1;
    assign wr_idx_m1 = r_wr_idx - 1'b1;

    assign len_sat = (r_best == LEN_MAX) ? LEN_MAX : r_best + 1'b1;

    // Shared comparator.
    always_comb begin
        case (r_state)
            ST_QUERY: begin
                cmp_a = r_rd_data;
                cmp_b = r_best;
            end
            ST_UPDATE: begin
                cmp_a = r_len;
                cmp_b = r_rd_data;
            end
            ST_LEN: begin
                cmp_a = len_sat;
                cmp_b = r_run;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end
    assign cmp_gt = cmp_a > cmp_b;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT_CLR: begin
                if (clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) n_state = s_axis_tuser[0] ? ST_SEQ_CLR : ST_QUERY;
            end
            ST_SEQ_CLR: begin
                if (clr_last) n_state = ST_QUERY;
            end
            ST_QUERY: begin
                if (r_idx == '0 && !r_pend) n_state = ST_LEN;
            end
            ST_LEN: begin
                n_state = r_upd_ok ? ST_UPDATE : ST_DONE;
            end
            ST_UPDATE: begin
                if (!in_range && !r_pend) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_rank   = r_rank;
        n_upd_ok = r_upd_ok;
        n_idx    = r_idx;
        n_wr_idx = r_wr_idx;
        n_pend   = r_pend;
        n_best   = r_best;
        n_len    = r_len;
        n_run    = r_run;
        n_clr    = r_clr;
        mem_re   = 1'b0;
        mem_ra   = idx_m1[AW-1:0];
        mem_we   = 1'b0;
        mem_wa   = r_clr;
        mem_wd   = '0;
        case (r_state)
            ST_INIT_CLR, ST_SEQ_CLR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                n_run  = '0;
            end
            ST_IDLE: begin
                n_clr = '0;
                if (in_accept) begin
                    n_rank   = in_rank;
                    n_upd_ok = (rank_c != '0) && (rank_c <= size_c);
                    n_idx    = XW'(q_c);
                    n_pend   = 1'b0;
                    n_best   = '0;
                end
            end
            ST_QUERY: begin
                if (r_pend && cmp_gt) begin
                    n_best = r_rd_data;
                end
                if (r_idx != '0) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_idx  = step_idx;
                end else begin
                    n_pend = 1'b0;
                end
            end
            ST_LEN: begin
                n_len  = len_sat;
                if (cmp_gt) begin
                    n_run = len_sat;
                end
                n_idx  = XW'(r_rank);
                n_pend = 1'b0;
            end
            ST_UPDATE: begin
                if (r_pend && cmp_gt) begin
                    mem_we = 1'b1;
                    mem_wa = wr_idx_m1[AW-1:0];
                    mem_wd = r_len;
                end
                if (in_range) begin
                    mem_re   = 1'b1;
                    n_pend   = 1'b1;
                    n_wr_idx = r_idx;
                    n_idx    = step_idx;
                end else begin
                    n_pend = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT_CLR;
            r_rank_count <= RANK_COUNT_RESET;
            r_clr        <= '0;
            r_pend       <= 1'b0;
            r_run        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_run   <= n_run;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rank_count <= i_cfg_data;
            end
            r_out_valid <= out_load || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank   <= n_rank;
        r_upd_ok <= n_upd_ok;
        r_idx    <= n_idx;
        r_wr_idx <= n_wr_idx;
        r_best   <= n_best;
        r_len    <= n_len;
        if (out_load) begin
            r_out_end  <= r_len;
            r_out_best <= r_run;
        end
    end

    // Tree memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_tree[mem_ra];
        end
    end

    assign s_axis_tready = r_state == ST_IDLE;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * LEN_W){1'b0}}, r_out_best, r_out_end};

    // The update chain never reads the entry it is writing in the same cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("tree read and write hit the same entry");

    // The query walk stays inside the active tree.
    a_query_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QUERY) |-> (CW'(r_idx) <= size_c))
        else $error("query index beyond active size");

    // The running best never falls below the length just reported.
    a_best_covers_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_best >= r_out_end))
        else $error("best_length below ending_length");

    // A taken word keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input ready right after accept");

endmodule
